>>> design/rhsv_pkg.sv
// package for the rgb to hsv converter: widths, hue constants, queue entry and status types
// no dependencies; compiled before every other file of the block

package rhsv_pkg;

  localparam int unsigned COLOR_W        = 8;
  localparam int unsigned HUE_W          = 15;
  localparam int unsigned SAT_W          = 16;
  localparam int unsigned NUM_W          = 11;   // sector numerator, up to 6 * 255
  localparam int unsigned SAT_SCALE_BITS = 15;   // saturation scaled by 32768
  localparam int unsigned HUE_INT_BITS   = 9;    // whole degrees stay below 512

  localparam int unsigned HUE_FRAC_DEF       = 6;
  localparam int unsigned DEG_PER_SECTOR     = 60;
  localparam int unsigned RED_WRAP_SECTORS   = 6;  // wrap of a negative red sector hue
  localparam int unsigned GREEN_BASE_SECTORS = 2;
  localparam int unsigned BLUE_BASE_SECTORS  = 4;
  localparam int unsigned FULL_CIRCLE_DEG    = 360;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [COLOR_W-1:0] diff;
    logic [COLOR_W-1:0] vmax;
  } rhsv_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rhsv_qstat_t;

endpackage

>>> design/rhsv_if.sv
// channel interfaces of the rgb to hsv converter: pixel in, hsv result out
// depends on rhsv_pkg for the field widths

interface rhsv_in_if import rhsv_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_out_if import rhsv_pkg::*;;
  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue;
  logic [SAT_W-1:0]   saturation;
  logic [COLOR_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

>>> design/rgb_to_hsv_converter_top.sv
// top level of the rgb to hsv converter: front end, queue, divider back end
// depends on rhsv_pkg, rhsv_if, rhsv_front, rhsv_queue and rhsv_back

// Converts one 8-bit rgb pixel per transaction to hsv: brightness is the largest
// channel, saturation is floor((max-min)*32768/max) and zero for black, hue is in
// units of 1/2^HUE_FRACTION_BITS degree (1/64 by default), zero for gray pixels,
// masked to 15 bits. The block takes one pixel every clock while the output is not
// stalled and holds no state between pixels. A result passes through the front
// register, the queue, one register per divider stage and the output register;
// the stage count is set by the two restoring dividers, which produce one quotient
// bit per pipeline stage. A stalled output freezes the divider pipeline; the
// four-entry queue and the front register then take up to five more pixels before
// the input stalls.

module rgb_to_hsv_converter_top import rhsv_pkg::*; #(
  parameter int unsigned HUE_FRACTION_BITS = HUE_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rhsv_in_if.sink    in_ch,
  rhsv_out_if.source out_ch
);

  // front end to queue
  logic        push;
  rhsv_item_t  push_item;
  // queue to back end
  logic        pop;
  rhsv_item_t  pop_item;
  rhsv_qstat_t q_stat;

  // max, min and sector numerator, registered once
  rhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decouples the two halves so each may stall on its own
  rhsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // hue and saturation dividers with output register
  rhsv_back #(.HUE_FRACTION_BITS(HUE_FRACTION_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_item (pop_item),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

>>> design/rhsv_front.sv
// front end: takes a pixel, finds max, min and the hue sector numerator, one register stage
// depends on rhsv_pkg and rhsv_in_if

module rhsv_front import rhsv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rhsv_in_if.sink     in_ch,
  input  rhsv_qstat_t q_stat,
  output logic        push,
  output rhsv_item_t  push_item
);

  logic               valid_r;
  rhsv_item_t         item_r;
  rhsv_item_t         item_nxt;
  logic [COLOR_W-1:0] vmin;
  logic [NUM_W-1:0]   r_ext, g_ext, b_ext, d_ext;

  assign push        = valid_r && !q_stat.full;
  assign in_ch.ready = !valid_r || !q_stat.full;
  assign push_item   = item_r;

  assign r_ext = NUM_W'(in_ch.red);
  assign g_ext = NUM_W'(in_ch.green);
  assign b_ext = NUM_W'(in_ch.blue);

  always_comb begin
    item_nxt.vmax = in_ch.red;
    vmin          = in_ch.red;
    if (in_ch.green > item_nxt.vmax) item_nxt.vmax = in_ch.green;
    if (in_ch.blue > item_nxt.vmax) item_nxt.vmax = in_ch.blue;
    if (in_ch.green < vmin) vmin = in_ch.green;
    if (in_ch.blue < vmin) vmin = in_ch.blue;
    item_nxt.diff = item_nxt.vmax - vmin;
    d_ext         = NUM_W'(item_nxt.diff);
    // red wins ties, then green
    if (item_nxt.vmax == in_ch.red) begin
      if (in_ch.green >= in_ch.blue) begin
        item_nxt.num = g_ext - b_ext;
      end else begin
        item_nxt.num = NUM_W'(RED_WRAP_SECTORS) * d_ext - (b_ext - g_ext);
      end
    end else if (item_nxt.vmax == in_ch.green) begin
      item_nxt.num = b_ext + NUM_W'(GREEN_BASE_SECTORS) * d_ext - r_ext;
    end else begin
      item_nxt.num = r_ext + NUM_W'(BLUE_BASE_SECTORS) * d_ext - g_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> design/rhsv_queue.sv
// short queue between the front end and the divider back end
// depends on rhsv_pkg for the entry and status types

module rhsv_queue import rhsv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rhsv_item_t  push_item,
  input  logic        pop,
  output rhsv_item_t  pop_item,
  output rhsv_qstat_t q_stat
);

  rhsv_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.valid = (count_r != '0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

>>> design/rhsv_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, byte divisor
// depends on rhsv_pkg for the divisor width

module rhsv_div_pipe import rhsv_pkg::*; #(
  parameter int unsigned STAGES = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [STAGES+COLOR_W-1:0]  num_i,
  input  logic [COLOR_W-1:0]         den_i,
  output logic [STAGES-1:0]          quo_o
);

  // the upper byte of the dividend must already be below the divisor
  localparam int unsigned NW = STAGES + COLOR_W;

  logic [COLOR_W-1:0] rem_r [STAGES-1];
  logic [COLOR_W-1:0] den_r [STAGES-1];
  logic [STAGES-1:0]  low_r [STAGES-1];
  logic [STAGES-1:0]  quo_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [COLOR_W-1:0] rem_in, den_in;
    logic [STAGES-1:0]  low_in, quo_in;
    logic [COLOR_W:0]   trial, sub;
    logic               take;

    if (s == 0) begin : g_first
      assign rem_in = num_i[NW-1:STAGES];
      assign low_in = num_i[STAGES-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = {rem_in, low_in[STAGES-1]};
    assign sub   = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= {quo_in[STAGES-2:0], take};
      end
    end

    if (s < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? sub[COLOR_W-1:0] : trial[COLOR_W-1:0];
          low_r[s] <= {low_in[STAGES-2:0], 1'b0};
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[STAGES-1];

endmodule

>>> design/rhsv_back.sv
// back end: hue and saturation dividers, side data delay line and output register
// depends on rhsv_pkg, rhsv_out_if and rhsv_div_pipe

module rhsv_back import rhsv_pkg::*; #(
  parameter int unsigned HUE_FRACTION_BITS = HUE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rhsv_item_t  pop_item,
  input  rhsv_qstat_t q_stat,
  output logic        pop,
  rhsv_out_if.source  out_ch
);

  localparam int unsigned HUE_QB   = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned STAGES   = (HUE_QB > SAT_W) ? HUE_QB : SAT_W;
  localparam int unsigned NW       = STAGES + COLOR_W;

  logic               en;
  logic [NW-1:0]      hue_top, sat_top;
  logic [STAGES-1:0]  hue_quo, sat_quo;
  logic               vld_r   [STAGES];
  logic               hzero_r [STAGES];
  logic               szero_r [STAGES];
  logic [COLOR_W-1:0] vmax_r  [STAGES];
  logic               out_valid_r;
  logic [HUE_W-1:0]   hue_r;
  logic [SAT_W-1:0]   sat_r;
  logic [COLOR_W-1:0] bright_r;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && q_stat.valid;

  assign hue_top = (NW'(pop_item.num) * NW'(DEG_PER_SECTOR)) << HUE_FRACTION_BITS;
  assign sat_top = NW'(pop_item.diff) << SAT_SCALE_BITS;

  rhsv_div_pipe #(.STAGES(STAGES)) u_hue_div (
    .clk   (clk),
    .en    (en),
    .num_i (hue_top),
    .den_i (pop_item.diff),
    .quo_o (hue_quo)
  );

  rhsv_div_pipe #(.STAGES(STAGES)) u_sat_div (
    .clk   (clk),
    .en    (en),
    .num_i (sat_top),
    .den_i (pop_item.vmax),
    .quo_o (sat_quo)
  );

  for (genvar s = 0; s < STAGES; s++) begin : g_delay
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= (s == 0) ? q_stat.valid : vld_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (s == 0) begin
          hzero_r[s] <= (pop_item.diff == '0);
          szero_r[s] <= (pop_item.vmax == '0);
          vmax_r[s]  <= pop_item.vmax;
        end else begin
          hzero_r[s] <= hzero_r[(s == 0) ? 0 : s-1];
          szero_r[s] <= szero_r[(s == 0) ? 0 : s-1];
          vmax_r[s]  <= vmax_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[STAGES-1];
    end
  end

  // gray pixel gives zero hue, black pixel zero saturation
  always_ff @(posedge clk) begin
    if (en) begin
      hue_r    <= hzero_r[STAGES-1] ? '0 : hue_quo[HUE_W-1:0];
      sat_r    <= szero_r[STAGES-1] ? '0 : sat_quo[SAT_W-1:0];
      bright_r <= vmax_r[STAGES-1];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hue        = hue_r;
  assign out_ch.saturation = sat_r;
  assign out_ch.brightness = bright_r;

`ifndef SYNTHESIS
  localparam int unsigned HUE_LIMIT = FULL_CIRCLE_DEG << HUE_FRACTION_BITS;
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (HUE_QB <= HUE_W)) |-> (32'(hue_r) < HUE_LIMIT))
    else $error("hue beyond full circle");
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(sat_r) <= (32'd1 << SAT_SCALE_BITS)))
    else $error("saturation above unity");
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (bright_r == '0)) |-> ((sat_r == '0) && (hue_r == '0)))
    else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

>>> tb/sv/rgb_to_hsv_converter_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for rgb_to_hsv_converter_top: directed and random pixels
// depends on rhsv_pkg, rhsv_if and the converter rtl; predicts each hsv result itself

module rgb_to_hsv_converter_top_tb;
  import rhsv_pkg::*;

  localparam int unsigned HUE_FRAC      = HUE_FRAC_DEF;
  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned IDLE_LIMIT    = 5000;  // cycles with no transaction on either side
  localparam int unsigned DRAIN_CYCLES  = 64;    // well beyond the divider pipeline depth

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [COLOR_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    rgb_t pixel;
    hsv_t hsv;
  } hsv_expect_t;

  // receiver behaviour, picked at random and held for a random time
  typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_PERIODIC, SINK_SLOW} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic run_go = 1'b0;
  logic in_fire = 1'b0;

  rhsv_in_if  in_ch ();
  rhsv_out_if out_ch ();

  rgb_t        pixel_q[$];   // pixels still to be sent
  hsv_expect_t hsv_exp_q[$]; // predicted results in order of acceptance

  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned sink_left   = 0;
  int unsigned sink_tick   = 0;
  sink_mode_t  sink_mode   = SINK_FREE;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt     = 0;

  rgb_to_hsv_converter_top #(
    .HUE_FRACTION_BITS (HUE_FRAC)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hsv prediction in exact integer arithmetic
  function automatic hsv_t hsv_from_rgb(rgb_t px);
    int unsigned     r, g, b;
    int unsigned     vmax, vmin, span, sector_num;
    longint unsigned hue_full;
    hsv_t            res;
    r = px.red;
    g = px.green;
    b = px.blue;
    vmax = r;
    vmin = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    span = vmax - vmin;
    res.brightness = COLOR_W'(vmax);
    // black pixel has no saturation
    res.saturation = (vmax == 0) ? '0 : SAT_W'((span << SAT_SCALE_BITS) / vmax);
    if (span == 0) begin
      // gray pixel, hue undefined and reported as zero
      res.hue = '0;
    end else begin
      // red wins ties, then green; a negative red sector wraps by six sectors
      if (vmax == r) begin
        sector_num = (g >= b) ? (g - b) : (RED_WRAP_SECTORS * span - (b - g));
      end else if (vmax == g) begin
        sector_num = b + GREEN_BASE_SECTORS * span - r;
      end else begin
        sector_num = r + BLUE_BASE_SECTORS * span - g;
      end
      hue_full = (longint'(DEG_PER_SECTOR) * sector_num) << HUE_FRAC;
      res.hue = HUE_W'(hue_full / span);
    end
    return res;
  endfunction

  task automatic queue_pixel(input int unsigned r, input int unsigned g, input int unsigned b);
    rgb_t px;
    px.red   = COLOR_W'(r);
    px.green = COLOR_W'(g);
    px.blue  = COLOR_W'(b);
    pixel_q.push_back(px);
  endtask

  function automatic int unsigned extreme_or_any();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    int unsigned base, shared, other;
    rst_n = 1'b0;

    // directed corners
    queue_pixel(0, 0, 0);         // black
    queue_pixel(255, 255, 255);   // white, gray with full brightness
    queue_pixel(128, 128, 128);   // mid gray
    queue_pixel(1, 1, 1);         // darkest non-black gray
    queue_pixel(255, 0, 0);       // pure red
    queue_pixel(0, 255, 0);       // pure green
    queue_pixel(0, 0, 255);       // pure blue
    queue_pixel(255, 255, 0);     // red and green tie, red wins
    queue_pixel(0, 255, 255);     // green and blue tie, green wins
    queue_pixel(255, 0, 255);     // red and blue tie, red sector wraps
    queue_pixel(255, 0, 1);       // red sector just below 360 degrees
    queue_pixel(255, 10, 0);      // red sector, positive hue
    queue_pixel(100, 255, 0);     // green sector, blue below red
    queue_pixel(0, 255, 100);     // green sector, blue above red
    queue_pixel(100, 0, 255);     // blue sector, red above green
    queue_pixel(0, 100, 255);     // blue sector, green above red
    queue_pixel(1, 0, 0);         // smallest non-black max, full saturation
    queue_pixel(0, 0, 1);
    queue_pixel(255, 254, 254);   // span of one at full brightness
    queue_pixel(254, 255, 255);
    queue_pixel(200, 100, 150);
    queue_pixel(3, 2, 1);

    // random part: mostly free values, plus near-gray, ties and extremes
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      case ($urandom_range(0, 9))
        5, 6: begin
          base = $urandom_range(2, 253);
          queue_pixel(base - 2 + $urandom_range(0, 4), base - 2 + $urandom_range(0, 4),
                      base - 2 + $urandom_range(0, 4));
        end
        7: begin
          shared = $urandom_range(0, 255);
          other  = $urandom_range(0, 255);
          case ($urandom_range(0, 2))
            0: queue_pixel(other, shared, shared);
            1: queue_pixel(shared, other, shared);
            default: queue_pixel(shared, shared, other);
          endcase
        end
        8, 9: queue_pixel(extreme_or_any(), extreme_or_any(), extreme_or_any());
        default: queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
      endcase
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk) run_go <= 1'b1;

    // everything sent, everything received, then let the pipeline run dry
    while (pixel_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (hsv_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog on a stuck handshake
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!run_go || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // pixel driver: bursts of random length, random gaps, valid held until accepted
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (in_fire) begin
      void'(pixel_q.pop_front());
    end
    if (!run_go) begin
      in_ch.valid <= 1'b0;
      in_ch.red   <= '0;
      in_ch.green <= '0;
      in_ch.blue  <= '0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.red   <= pixel_q[0].red;
        in_ch.green <= pixel_q[0].green;
        in_ch.blue  <= pixel_q[0].blue;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          // a quarter of bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: free running, random, periodic or mostly stalled
  always @(negedge clk) begin
    if (!run_go) begin
      out_ch.ready <= 1'b0;
    end else begin
      sink_tick <= sink_tick + 1;
      if (sink_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
        sink_left <= $urandom_range(20, 200);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        SINK_FREE:     out_ch.ready <= 1'b1;
        SINK_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: out_ch.ready <= (sink_tick % 3) == 0;
        default:       out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: predict on each accepted pixel, compare on each accepted result
  always @(posedge clk) begin
    hsv_expect_t want;
    rgb_t        px;
    if (in_ch.valid && in_ch.ready) begin
      px.red   = in_ch.red;
      px.green = in_ch.green;
      px.blue  = in_ch.blue;
      want.pixel = px;
      want.hsv   = hsv_from_rgb(px);
      hsv_exp_q.push_back(want);
    end
    if (out_ch.valid && out_ch.ready) begin
      if (hsv_exp_q.size() == 0) begin
        $error("unexpected result transaction: hue %0d saturation %0d brightness %0d",
               out_ch.hue, out_ch.saturation, out_ch.brightness);
        err_cnt <= err_cnt + 1;
      end else begin
        want = hsv_exp_q.pop_front();
        if (out_ch.hue !== want.hsv.hue ||
            out_ch.saturation !== want.hsv.saturation ||
            out_ch.brightness !== want.hsv.brightness) begin
          err_cnt <= err_cnt + 1;
        end
        if (out_ch.hue !== want.hsv.hue) begin
          $error("hue mismatch for rgb %0d/%0d/%0d: expected %0d, actual %0d",
                 want.pixel.red, want.pixel.green, want.pixel.blue,
                 want.hsv.hue, out_ch.hue);
        end
        if (out_ch.saturation !== want.hsv.saturation) begin
          $error("saturation mismatch for rgb %0d/%0d/%0d: expected %0d, actual %0d",
                 want.pixel.red, want.pixel.green, want.pixel.blue,
                 want.hsv.saturation, out_ch.saturation);
        end
        if (out_ch.brightness !== want.hsv.brightness) begin
          $error("brightness mismatch for rgb %0d/%0d/%0d: expected %0d, actual %0d",
                 want.pixel.red, want.pixel.green, want.pixel.blue,
                 want.hsv.brightness, out_ch.brightness);
        end
      end
    end
  end

endmodule
